// File: rtl/lbjh_pkg.sv
// Shared types, widths, codes and defaults of the log-binned joint histogram.
package lbjh_pkg;

  localparam int SNR_BINS_DEF    = 256;
  localparam int CHISQ_BINS_DEF  = 256;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int VAL_W      = 16;
  localparam int INV_W      = 20;
  localparam int BIN_OUT_W  = 8;
  localparam int CNT_OUT_W  = 32;
  localparam int ACT_W      = 2;
  localparam int PROD_W     = VAL_W + INV_W;
  localparam int FRAC_SHIFT = 21;
  localparam int IDX_W      = PROD_W - FRAC_SHIFT;
  localparam int MAX_BIN_W  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  typedef logic [ACT_W-1:0]        action_t;
  typedef logic signed [VAL_W-1:0] q511_t;
  typedef logic [INV_W-1:0]        inv_t;
  typedef logic [BIN_OUT_W-1:0]    bin8_t;
  typedef logic [CNT_OUT_W-1:0]    cnt32_t;
  typedef logic [PROD_W-1:0]       prod_t;
  typedef logic [MAX_BIN_W-1:0]    bin_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]   cfg_data_t;

  localparam action_t ACT_RECORD = 2'd0;
  localparam action_t ACT_CLEAR  = 2'd1;
  localparam action_t ACT_READ   = 2'd2;
  localparam action_t ACT_NONE   = 2'd3;

  localparam cfg_idx_t REG_SNR_LOW   = 3'd0;
  localparam cfg_idx_t REG_SNR_HIGH  = 3'd1;
  localparam cfg_idx_t REG_SNR_INV   = 3'd2;
  localparam cfg_idx_t REG_CHISQ_LOW = 3'd3;
  localparam cfg_idx_t REG_CHISQ_HIGH = 3'd4;
  localparam cfg_idx_t REG_CHISQ_INV = 3'd5;

  localparam q511_t SNR_LOW_RST    = 16'sd0;
  localparam q511_t SNR_HIGH_RST   = 16'sd4096;
  localparam inv_t  SNR_INV_RST    = 20'd131072;
  localparam q511_t CHISQ_LOW_RST  = -16'sd2048;
  localparam q511_t CHISQ_HIGH_RST = 16'sd8192;
  localparam inv_t  CHISQ_INV_RST  = 20'd52429;

  localparam prod_t HALF_Q21 = prod_t'(1) << (FRAC_SHIFT - 1);

  // Maps a value to its bin from the edge compares and the scaled offset.
  function automatic bin_t bin_of(logic below, logic above, prod_t prod, bin_t last);
    logic [IDX_W-1:0] idx;
    bin_t             res;
    idx = IDX_W'((prod - HALF_Q21) >> FRAC_SHIFT);
    if (below) begin
      res = '0;
    end else if (above) begin
      res = last;
    end else if (prod < HALF_Q21) begin
      res = '0;
    end else if (idx > IDX_W'(last)) begin
      res = last;
    end else begin
      res = MAX_BIN_W'(idx);
    end
    return res;
  endfunction

endpackage

// File: rtl/lbjh_in_if.sv
// Input channel carrying event and command transactions.
interface lbjh_in_if import lbjh_pkg::*; ();
  logic    valid;
  logic    ready;
  action_t action;
  q511_t   log_snr;
  q511_t   log_chisq;
  bin8_t   read_snr_bin;
  bin8_t   read_chisq_bin;

  modport source (output valid, action, log_snr, log_chisq, read_snr_bin, read_chisq_bin,
                  input ready);
  modport sink (input valid, action, log_snr, log_chisq, read_snr_bin, read_chisq_bin,
                output ready);
endinterface

// File: rtl/lbjh_out_if.sv
// Result channel carrying bin indexes and counts.
interface lbjh_out_if import lbjh_pkg::*; ();
  logic   valid;
  logic   ready;
  bin8_t  snr_bin;
  bin8_t  chisq_bin;
  cnt32_t snr_count;
  cnt32_t chisq_count;
  cnt32_t joint_count;

  modport source (output valid, snr_bin, chisq_bin, snr_count, chisq_count, joint_count,
                  input ready);
  modport sink (input valid, snr_bin, chisq_bin, snr_count, chisq_count, joint_count,
                output ready);
endinterface

// File: rtl/lbjh_cfg_if.sv
// Configuration write channel with register index and data.
interface lbjh_cfg_if import lbjh_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/log_binned_joint_histogram_unit.sv
// Log-binned joint histogram top level with SNR and chi-square marginals.
// Record, read and unused-action transactions go through these steps in order: accept with the
// offset multiply, bin and memory read address, then read-modify-write of the counters.
// The result register loads in read-modify-write once the output is free; one transaction at a time.
// A clear transaction sweeps all 2^(clog2(SNR_BINS)+clog2(CHISQ_BINS)) joint entries
// (65536 entries by default), one per cycle, before its result; reset runs the same sweep.
// Reset is synchronous, active low, and restores the default configuration registers.
module log_binned_joint_histogram_unit import lbjh_pkg::*; #(
  parameter int SNR_BINS    = SNR_BINS_DEF,
  parameter int CHISQ_BINS  = CHISQ_BINS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lbjh_in_if.sink    in_ch,
  lbjh_out_if.source out_ch,
  lbjh_cfg_if.sink   cfg_ch
);

  localparam int SB_W = $clog2(SNR_BINS);
  localparam int CB_W = $clog2(CHISQ_BINS);
  localparam int JA_W = SB_W + CB_W;

  localparam bin_t SNR_LAST   = MAX_BIN_W'(SNR_BINS - 1);
  localparam bin_t CHISQ_LAST = MAX_BIN_W'(CHISQ_BINS - 1);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ADDR  = 3'd2;
  localparam logic [2:0] S_RMW   = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  logic [2:0] state_r, state_nxt;
  logic [JA_W-1:0] sweep_r;
  logic sweeping, sweep_last;

  q511_t snr_low_r, snr_high_r, chisq_low_r, chisq_high_r;
  inv_t  snr_inv_r, chisq_inv_r;

  action_t act_r;
  prod_t   prod_s_r, prod_c_r;
  logic    below_s_r, above_s_r, below_c_r, above_c_r;
  bin8_t   rd_sb_r, rd_cb_r;
  logic [VAL_W-1:0] diff_s, diff_c;

  logic [SB_W-1:0] sb_r, sb_nxt;
  logic [CB_W-1:0] cb_r, cb_nxt;
  bin_t sb_calc, cb_calc;

  count_t snr_rd, chisq_rd, joint_rd;
  count_t snr_inc, chisq_inc, joint_inc;
  logic   snr_we, chisq_we, joint_we;
  logic [SB_W-1:0] snr_waddr;
  logic [CB_W-1:0] chisq_waddr;
  logic [JA_W-1:0] joint_waddr;
  count_t wdata_s, wdata_c, wdata_j;

  logic in_acc, load_out, counted;
  logic out_valid_r;
  bin8_t out_sb_r, out_cb_r;
  cnt32_t out_sc_r, out_cc_r, out_jc_r;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign sweeping   = (state_r == S_INIT) || (state_r == S_CLEAR);
  assign sweep_last = (sweep_r == '1);
  assign load_out   = (state_r == S_RMW) && (!out_valid_r || out_ch.ready);
  assign counted    = load_out && (act_r == ACT_RECORD);

  assign diff_s = VAL_W'(in_ch.log_snr - snr_low_r);
  assign diff_c = VAL_W'(in_ch.log_chisq - chisq_low_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snr_low_r    <= SNR_LOW_RST;
      snr_high_r   <= SNR_HIGH_RST;
      snr_inv_r    <= SNR_INV_RST;
      chisq_low_r  <= CHISQ_LOW_RST;
      chisq_high_r <= CHISQ_HIGH_RST;
      chisq_inv_r  <= CHISQ_INV_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_SNR_LOW:    snr_low_r    <= cfg_ch.data[VAL_W-1:0];
        REG_SNR_HIGH:   snr_high_r   <= cfg_ch.data[VAL_W-1:0];
        REG_SNR_INV:    snr_inv_r    <= cfg_ch.data[INV_W-1:0];
        REG_CHISQ_LOW:  chisq_low_r  <= cfg_ch.data[VAL_W-1:0];
        REG_CHISQ_HIGH: chisq_high_r <= cfg_ch.data[VAL_W-1:0];
        REG_CHISQ_INV:  chisq_inv_r  <= cfg_ch.data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r     <= in_ch.action;
      below_s_r <= in_ch.log_snr < snr_low_r;
      above_s_r <= in_ch.log_snr > snr_high_r;
      below_c_r <= in_ch.log_chisq < chisq_low_r;
      above_c_r <= in_ch.log_chisq > chisq_high_r;
      prod_s_r  <= PROD_W'(diff_s) * PROD_W'(snr_inv_r);
      prod_c_r  <= PROD_W'(diff_c) * PROD_W'(chisq_inv_r);
      rd_sb_r   <= in_ch.read_snr_bin;
      rd_cb_r   <= in_ch.read_chisq_bin;
    end
    sb_r <= sb_nxt;
    cb_r <= cb_nxt;
  end

  always_comb begin
    sb_calc = '0;
    cb_calc = '0;
    case (act_r)
      ACT_RECORD: begin
        sb_calc = bin_of(below_s_r, above_s_r, prod_s_r, SNR_LAST);
        cb_calc = bin_of(below_c_r, above_c_r, prod_c_r, CHISQ_LAST);
      end
      ACT_READ: begin
        sb_calc = (MAX_BIN_W'(rd_sb_r) > SNR_LAST) ? SNR_LAST : MAX_BIN_W'(rd_sb_r);
        cb_calc = (MAX_BIN_W'(rd_cb_r) > CHISQ_LAST) ? CHISQ_LAST : MAX_BIN_W'(rd_cb_r);
      end
      default: ;
    endcase
    sb_nxt = (state_r == S_ADDR) ? SB_W'(sb_calc) : sb_r;
    cb_nxt = (state_r == S_ADDR) ? CB_W'(cb_calc) : cb_r;
  end

  assign snr_inc   = (snr_rd == '1) ? snr_rd : snr_rd + 1'b1;
  assign chisq_inc = (chisq_rd == '1) ? chisq_rd : chisq_rd + 1'b1;
  assign joint_inc = (joint_rd == '1) ? joint_rd : joint_rd + 1'b1;

  assign snr_we      = sweeping || counted;
  assign chisq_we    = sweeping || counted;
  assign joint_we    = sweeping || counted;
  assign snr_waddr   = sweeping ? sweep_r[SB_W-1:0] : sb_r;
  assign chisq_waddr = sweeping ? sweep_r[CB_W-1:0] : cb_r;
  assign joint_waddr = sweeping ? sweep_r : {sb_r, cb_r};
  assign wdata_s     = sweeping ? '0 : snr_inc;
  assign wdata_c     = sweeping ? '0 : chisq_inc;
  assign wdata_j     = sweeping ? '0 : joint_inc;

  lbjh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(1 << SB_W)) u_snr_ram (
    .clk   (clk),
    .we    (snr_we),
    .waddr (snr_waddr),
    .wdata (wdata_s),
    .raddr (sb_nxt),
    .rdata (snr_rd)
  );

  lbjh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(1 << CB_W)) u_chisq_ram (
    .clk   (clk),
    .we    (chisq_we),
    .waddr (chisq_waddr),
    .wdata (wdata_c),
    .raddr (cb_nxt),
    .rdata (chisq_rd)
  );

  lbjh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(1 << JA_W)) u_joint_ram (
    .clk   (clk),
    .we    (joint_we),
    .waddr (joint_waddr),
    .wdata (wdata_j),
    .raddr ({sb_nxt, cb_nxt}),
    .rdata (joint_rd)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_ch.action == ACT_CLEAR) ? S_CLEAR : S_ADDR;
        end
      end
      S_ADDR:  state_nxt = S_RMW;
      S_RMW: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (sweep_last) begin
          state_nxt = S_RMW;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweeping ? sweep_r + 1'b1 : '0;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      case (act_r)
        ACT_RECORD: begin
          out_sb_r <= BIN_OUT_W'(sb_r);
          out_cb_r <= BIN_OUT_W'(cb_r);
          out_sc_r <= CNT_OUT_W'(snr_inc);
          out_cc_r <= CNT_OUT_W'(chisq_inc);
          out_jc_r <= CNT_OUT_W'(joint_inc);
        end
        ACT_READ: begin
          out_sb_r <= BIN_OUT_W'(sb_r);
          out_cb_r <= BIN_OUT_W'(cb_r);
          out_sc_r <= CNT_OUT_W'(snr_rd);
          out_cc_r <= CNT_OUT_W'(chisq_rd);
          out_jc_r <= CNT_OUT_W'(joint_rd);
        end
        default: begin
          out_sb_r <= '0;
          out_cb_r <= '0;
          out_sc_r <= '0;
          out_cc_r <= '0;
          out_jc_r <= '0;
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.snr_bin     = out_sb_r;
  assign out_ch.chisq_bin   = out_cb_r;
  assign out_ch.snr_count   = out_sc_r;
  assign out_ch.chisq_count = out_cc_r;
  assign out_ch.joint_count = out_jc_r;

`ifndef SYNTHESIS
  a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.action == ACT_CLEAR |=> state_r == S_CLEAR && sweep_r == '0)
    else $error("Clear transaction did not start a sweep.");

  a_sweep_advances: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && sweeping && !sweep_last |=> sweeping && sweep_r == $past(sweep_r) + 1'b1)
    else $error("Clearing sweep skipped or stalled.");

  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    joint_we |-> sweeping || (state_r == S_RMW && act_r == ACT_RECORD))
    else $error("Counter memory written outside a sweep or a record update.");

  a_record_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    counted |-> wdata_j != '0 && wdata_s != '0 && wdata_c != '0)
    else $error("Record update wrote a zero count.");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready ##1 !in_ch.ready)
    else $error("Transaction accepted while another was in flight.");
`endif

endmodule

// File: rtl/lbjh_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module lbjh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: verif/lbjh_tb_pkg.sv
// Scoreboard for the log-binned joint histogram: prediction of counts and result checking.
package lbjh_tb_pkg;
  import lbjh_pkg::*;

  typedef struct packed {
    bin8_t  snr_bin;
    bin8_t  chisq_bin;
    cnt32_t snr_count;
    cnt32_t chisq_count;
    cnt32_t joint_count;
  } hist_result_t;

  class histogram_scoreboard;
    q511_t        snr_low;
    q511_t        snr_high;
    inv_t         snr_inv;
    q511_t        chisq_low;
    q511_t        chisq_high;
    inv_t         chisq_inv;
    cnt32_t       snr_counts[SNR_BINS_DEF];
    cnt32_t       chisq_counts[CHISQ_BINS_DEF];
    cnt32_t       joint_counts[int];
    hist_result_t expected_results[$];
    bin8_t        last_snr_bin;
    bin8_t        last_chisq_bin;
    int           mismatches;

    function new();
      snr_low        = SNR_LOW_RST;
      snr_high       = SNR_HIGH_RST;
      snr_inv        = SNR_INV_RST;
      chisq_low      = CHISQ_LOW_RST;
      chisq_high     = CHISQ_HIGH_RST;
      chisq_inv      = CHISQ_INV_RST;
      last_snr_bin   = '0;
      last_chisq_bin = '0;
      mismatches     = 0;
      clear_counts();
    endfunction

    function void clear_counts();
      foreach (snr_counts[i]) snr_counts[i] = '0;
      foreach (chisq_counts[i]) chisq_counts[i] = '0;
      joint_counts.delete();
    endfunction

    function void set_register(cfg_idx_t idx, cfg_data_t data);
      case (idx)
        REG_SNR_LOW:    snr_low    = $signed(data[VAL_W-1:0]);
        REG_SNR_HIGH:   snr_high   = $signed(data[VAL_W-1:0]);
        REG_SNR_INV:    snr_inv    = data[INV_W-1:0];
        REG_CHISQ_LOW:  chisq_low  = $signed(data[VAL_W-1:0]);
        REG_CHISQ_HIGH: chisq_high = $signed(data[VAL_W-1:0]);
        REG_CHISQ_INV:  chisq_inv  = data[INV_W-1:0];
        default: ;
      endcase
    endfunction

    function bin8_t axis_bin(q511_t v, q511_t low, q511_t high, inv_t inv, int nbins);
      longint prod;
      longint idx;
      if (v < low) return '0;
      if (v > high) return bin8_t'(nbins - 1);
      prod = longint'(int'(v) - int'(low)) * longint'(inv);
      if (prod < (longint'(1) << 20)) return '0;
      idx = (prod - (longint'(1) << 20)) >>> 21;
      if (idx > nbins - 1) idx = nbins - 1;
      return bin8_t'(idx);
    endfunction

    function cnt32_t saturating_inc(cnt32_t c);
      return (c == '1) ? c : c + 1'b1;
    endfunction

    function void note_input(action_t act, q511_t log_snr, q511_t log_chisq,
                             bin8_t read_snr, bin8_t read_chisq);
      hist_result_t r;
      int           j;
      r = '0;
      case (act)
        ACT_RECORD: begin
          r.snr_bin   = axis_bin(log_snr, snr_low, snr_high, snr_inv, SNR_BINS_DEF);
          r.chisq_bin = axis_bin(log_chisq, chisq_low, chisq_high, chisq_inv, CHISQ_BINS_DEF);
          j = int'(r.snr_bin) * CHISQ_BINS_DEF + int'(r.chisq_bin);
          snr_counts[r.snr_bin]     = saturating_inc(snr_counts[r.snr_bin]);
          chisq_counts[r.chisq_bin] = saturating_inc(chisq_counts[r.chisq_bin]);
          joint_counts[j] = saturating_inc(joint_counts.exists(j) ? joint_counts[j] : '0);
          r.snr_count   = snr_counts[r.snr_bin];
          r.chisq_count = chisq_counts[r.chisq_bin];
          r.joint_count = joint_counts[j];
          last_snr_bin   = r.snr_bin;
          last_chisq_bin = r.chisq_bin;
        end
        ACT_CLEAR: clear_counts();
        ACT_READ: begin
          r.snr_bin   = read_snr;
          r.chisq_bin = read_chisq;
          j = int'(read_snr) * CHISQ_BINS_DEF + int'(read_chisq);
          r.snr_count   = snr_counts[read_snr];
          r.chisq_count = chisq_counts[read_chisq];
          r.joint_count = joint_counts.exists(j) ? joint_counts[j] : '0;
        end
        default: ;
      endcase
      expected_results.push_back(r);
    endfunction

    function void check_result(hist_result_t got);
      hist_result_t want;
      if (expected_results.size() == 0) begin
        if (mismatches < 10)
          $display("result transaction with nothing expected: bins %0d/%0d counts %0d/%0d/%0d",
                   got.snr_bin, got.chisq_bin, got.snr_count, got.chisq_count, got.joint_count);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (got.snr_bin != want.snr_bin || got.chisq_bin != want.chisq_bin ||
          got.snr_count != want.snr_count || got.chisq_count != want.chisq_count ||
          got.joint_count != want.joint_count) begin
        if (mismatches < 10)
          $display("mismatch: expected bins %0d/%0d counts %0d/%0d/%0d, got bins %0d/%0d %s %0d/%0d/%0d",
                   want.snr_bin, want.chisq_bin, want.snr_count, want.chisq_count,
                   want.joint_count, got.snr_bin, got.chisq_bin, "counts",
                   got.snr_count, got.chisq_count, got.joint_count);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// File: verif/tb_top.sv
// Top-level testbench of the log-binned joint histogram unit.
module tb_top;
  import lbjh_pkg::*;
  import lbjh_tb_pkg::*;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 175;

  logic clk = 1'b0;
  logic rst_n;

  lbjh_in_if  in_ch();
  lbjh_out_if out_ch();
  lbjh_cfg_if cfg_ch();

  histogram_scoreboard sb;
  cfg_data_t           reg_vals[REG_CHISQ_INV+1];
  int                  idle_pct  = 0;
  int                  stall_pct = 0;
  q511_t               last_snr  = '0;
  q511_t               last_chisq = '0;

  log_binned_joint_histogram_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #1 clk = ~clk;

  initial begin
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      sb.check_result('{snr_bin: out_ch.snr_bin, chisq_bin: out_ch.chisq_bin,
                        snr_count: out_ch.snr_count, chisq_count: out_ch.chisq_count,
                        joint_count: out_ch.joint_count});
    end
  end

  initial begin
    #8000000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_item(action_t act, q511_t ls, q511_t lc, bin8_t rs, bin8_t rc);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.action         <= act;
    in_ch.log_snr        <= ls;
    in_ch.log_chisq      <= lc;
    in_ch.read_snr_bin   <= rs;
    in_ch.read_chisq_bin <= rc;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_input(act, ls, lc, rs, rc);
    if (act == ACT_RECORD) begin
      last_snr   = ls;
      last_chisq = lc;
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_registers();
    for (int i = REG_SNR_LOW; i <= REG_CHISQ_INV; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= cfg_idx_t'(i);
      cfg_ch.data  <= reg_vals[i];
      do @(posedge clk); while (cfg_ch.ready !== 1'b1);
      sb.set_register(cfg_idx_t'(i), reg_vals[i]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic void set_axis(bit chisq, int low, int high, int inv);
    if (chisq) begin
      reg_vals[REG_CHISQ_LOW]  = cfg_data_t'(low);
      reg_vals[REG_CHISQ_HIGH] = cfg_data_t'(high);
      reg_vals[REG_CHISQ_INV]  = cfg_data_t'(inv);
    end else begin
      reg_vals[REG_SNR_LOW]  = cfg_data_t'(low);
      reg_vals[REG_SNR_HIGH] = cfg_data_t'(high);
      reg_vals[REG_SNR_INV]  = cfg_data_t'(inv);
    end
  endfunction

  function automatic void random_axis(bit chisq);
    int span;
    int low;
    int inv;
    span = int'($urandom_range(12000, 600));
    low  = int'($urandom_range(65535 - span, 0)) - 32768;
    inv  = (32'h2000_0000 / span) * int'($urandom_range(140, 60)) / 100;
    if (inv > 1048575) inv = 1048575;
    if (inv < 1) inv = 1;
    set_axis(chisq, low, low + span, inv);
  endfunction

  function automatic void select_config(int p);
    case (p)
      0: begin
        set_axis(1'b0, 0, 4096, 131072);
        set_axis(1'b1, -2048, 8192, 52429);
      end
      1: begin
        set_axis(1'b0, -32768, 32767, 1);
        set_axis(1'b1, -32768, 32767, 1048575);
      end
      2: begin
        set_axis(1'b0, 1000, -1000, 131072);
        set_axis(1'b1, 32767, -32768, 52429);
      end
      3: begin
        set_axis(1'b0, -4096, 4096, 0);
        random_axis(1'b1);
      end
      5: begin
        set_axis(1'b0, 1234, 1234, 1048575);
        random_axis(1'b1);
      end
      default: begin
        random_axis(1'b0);
        random_axis(1'b1);
      end
    endcase
  endfunction

  function automatic q511_t axis_value(q511_t low, q511_t high);
    int lo;
    int hi;
    int roll;
    lo   = (low < high) ? int'(low) : int'(high);
    hi   = (low < high) ? int'(high) : int'(low);
    roll = int'($urandom_range(99));
    if (roll < 15) return q511_t'($urandom);
    if (roll < 30) begin
      case ($urandom_range(3))
        0: return low;
        1: return high;
        2: return q511_t'(int'(low) - 1);
        default: return q511_t'(int'(high) + 1);
      endcase
    end
    lo = (lo > -32704) ? lo - 64 : -32768;
    hi = (hi < 32703) ? hi + 64 : 32767;
    return q511_t'(int'($urandom_range(hi - lo, 0)) + lo);
  endfunction

  task automatic random_item();
    int    roll;
    q511_t ls;
    q511_t lc;
    bin8_t rs;
    bin8_t rc;
    roll = int'($urandom_range(99));
    ls   = q511_t'($urandom);
    lc   = q511_t'($urandom);
    rs   = bin8_t'($urandom);
    rc   = bin8_t'($urandom);
    if (roll < 70) begin
      if ($urandom_range(3) == 0) begin
        ls = last_snr;
        lc = last_chisq;
      end else begin
        ls = axis_value(sb.snr_low, sb.snr_high);
        lc = axis_value(sb.chisq_low, sb.chisq_high);
      end
      send_item(ACT_RECORD, ls, lc, rs, rc);
    end else if (roll < 93) begin
      if ($urandom_range(1) == 0) begin
        rs = sb.last_snr_bin;
        rc = sb.last_chisq_bin;
      end
      send_item(ACT_READ, ls, lc, rs, rc);
    end else begin
      send_item(ACT_NONE, ls, lc, rs, rc);
    end
  endtask

  initial begin
    sb = new();
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.action         <= ACT_NONE;
    in_ch.log_snr        <= '0;
    in_ch.log_chisq      <= '0;
    in_ch.read_snr_bin   <= '0;
    in_ch.read_chisq_bin <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= REG_SNR_LOW;
    cfg_ch.data          <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    select_config(0);
    write_registers();
    send_item(ACT_RECORD, 16'sd0, -16'sd2048, 8'hFF, 8'hFF);
    send_item(ACT_RECORD, 16'sd4096, 16'sd8192, 8'h00, 8'h00);
    send_item(ACT_RECORD, -16'sd32768, -16'sd32768, 8'hFF, 8'h00);
    send_item(ACT_RECORD, 16'sd32767, 16'sd32767, 8'h00, 8'hFF);
    send_item(ACT_RECORD, -16'sd1, 16'sd8193, 8'h55, 8'hAA);
    send_item(ACT_RECORD, 16'sd2048, 16'sd3000, 8'hAA, 8'h55);
    send_item(ACT_RECORD, 16'sd2048, 16'sd3000, 8'h00, 8'h00);
    send_item(ACT_READ, 16'sd0, 16'sd0, 8'h00, 8'h00);
    send_item(ACT_READ, 16'sd0, 16'sd0, 8'hFF, 8'hFF);
    send_item(ACT_READ, -16'sd1, -16'sd1, 8'hAA, 8'h55);
    send_item(ACT_READ, 16'sd0, 16'sd0, sb.last_snr_bin, sb.last_chisq_bin);
    send_item(ACT_NONE, 16'sh5A5A, -16'sh2A5A, 8'hA5, 8'h5A);
    send_item(ACT_NONE, -16'sd1, -16'sd1, 8'hFF, 8'hFF);
    send_item(ACT_CLEAR, 16'sd0, 16'sd0, 8'h00, 8'h00);
    send_item(ACT_READ, 16'sd0, 16'sd0, 8'hFF, 8'hFF);
    send_item(ACT_RECORD, 16'sd2048, 16'sd3000, 8'h00, 8'h00);
    send_item(ACT_READ, 16'sd0, 16'sd0, sb.last_snr_bin, sb.last_chisq_bin);
    send_item(ACT_READ, 16'sd0, 16'sd0, 8'h00, 8'h00);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      select_config(p);
      write_registers();
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 72; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == 0 && p != 0 && p % 2 == 0)
          send_item(ACT_CLEAR, q511_t'($urandom), q511_t'($urandom),
                    bin8_t'($urandom), bin8_t'($urandom));
        else
          random_item();
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/lbjh_pkg.sv
rtl/lbjh_in_if.sv
rtl/lbjh_out_if.sv
rtl/lbjh_cfg_if.sv
rtl/lbjh_ram.sv
rtl/log_binned_joint_histogram_unit.sv
verif/lbjh_tb_pkg.sv
verif/tb_top.sv
